>>> rtl/swmp_pkg.sv
// Shared types and constants for the sliding window max pool block.
// Holds the configuration register map, register reset values and fixed limits.
// No dependencies.
package swmp_pkg;

  // Configuration port geometry.
  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  // Configuration register field widths.
  localparam int CFG_DIM_BITS = 11;
  localparam int CFG_WIN_BITS = 4;

  // Register reset values.
  localparam logic [CFG_DIM_BITS-1:0] IMAGE_WIDTH_RESET   = 11'd5;
  localparam logic [CFG_DIM_BITS-1:0] IMAGE_HEIGHT_RESET  = 11'd5;
  localparam logic [CFG_WIN_BITS-1:0] WINDOW_HEIGHT_RESET = 4'd3;
  localparam logic [CFG_WIN_BITS-1:0] WINDOW_WIDTH_RESET  = 4'd3;

  // Frame height limit and the row counter that follows from it.
  localparam int HEIGHT_LIMIT = 1024;
  localparam int HEIGHT_BITS  = 11;
  localparam int ROW_BITS     = 10;

  // Result buffer depth: covers the two pipeline stages plus steady flow.
  localparam int OUT_DEPTH = 4;

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_WINDOW_HEIGHT = 2'd2,
    REG_WINDOW_WIDTH  = 2'd3
  } cfg_reg_t;

endpackage

>>> rtl/swmp_line_store.sv
// Line store for the max pool block: one word per column, one sample lane per line.
// Synchronous (registered) read and a bypass for a same-edge write.
// Depends on nothing outside this file.
module swmp_line_store #(
  parameter int DEPTH     = 1024,
  parameter int WORD_BITS = 112
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [WORD_BITS-1:0]       rd_data,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [WORD_BITS-1:0]       wr_data
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] mem_q;
  logic [WORD_BITS-1:0] fwd_q;
  logic                 hit_q;

  // Memory array with registered read; a write at the same edge lands in fwd_q.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
      fwd_q <= wr_data;
    end
  end

  // Remember whether the read collided with a write of the same entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_q <= 1'b0;
    end else if (rd_en) begin
      hit_q <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = hit_q ? fwd_q : mem_q;

endmodule

>>> rtl/swmp_out_fifo.sv
// Result buffer for the max pool block: a small register FIFO on the output channel.
// Drives the output valid and reports its fill level for input flow control.
// Depends on nothing outside this file.
module swmp_out_fifo #(
  parameter int DEPTH     = 4,
  parameter int DATA_BITS = 17
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [DATA_BITS-1:0]         push_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [DATA_BITS-1:0]         out_data,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_BITS-1:0] slots [DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr;
  logic [PTR_BITS-1:0]  rd_ptr;
  logic                 pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = slots[rd_ptr];

  // Storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/sliding_window_max_pool_core.sv
// Top level of the sliding window max pool block: 2-D max pooling, stride 1, no padding.
// Uses swmp_pkg, swmp_line_store and swmp_out_fifo.
//
// Channel  Direction  Handshake                 Word
// config   in         psel/penable/pwrite/pready  paddr, pwdata, prdata
// pixel    in         in_valid / in_stall       pixel_value
// pooled   out        out_valid / out_stall     pooled_value, last_of_frame
//
// One pixel word is taken per cycle while in_stall is low. Stage 1 receives the column's
// line store word (registered read), forms the column maximum and writes the word back;
// stage 2 forms the window maximum, and its result goes through the result buffer.
// Reset clears counters and control only; there is no clearing pass over the line store.
// in_stall is high while the result buffer and the two stages hold four words between them.
// Any register write restarts the frame at row 0, column 0.
module sliding_window_max_pool_core #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_WINDOW  = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [swmp_pkg::ADDR_BITS-1:0]    paddr,
  input  logic [swmp_pkg::DATA_BITS-1:0]    pwdata,
  output logic [swmp_pkg::DATA_BITS-1:0]    prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [SAMPLE_BITS-1:0]     pixel_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [SAMPLE_BITS-1:0]     pooled_value,
  output logic                              last_of_frame
);
  import swmp_pkg::*;

  localparam int LINES      = MAX_WINDOW - 1;
  localparam int LINE_BITS  = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int WIDTH_BITS = $clog2(MAX_WIDTH + 1);
  localparam int WIN_BITS   = $clog2(MAX_WINDOW + 1);
  localparam int WORD_BITS  = LINES * SAMPLE_BITS;
  localparam int CNT_BITS   = $clog2(OUT_DEPTH + 1);

  // Configuration registers.
  logic [CFG_DIM_BITS-1:0] image_width;
  logic [CFG_DIM_BITS-1:0] image_height;
  logic [CFG_WIN_BITS-1:0] window_height;
  logic [CFG_WIN_BITS-1:0] window_width;

  // Effective sizes after clamping.
  logic [WIDTH_BITS-1:0]  w_eff;
  logic [HEIGHT_BITS-1:0] h_eff;
  logic [WIN_BITS-1:0]    kh_lim;
  logic [WIN_BITS-1:0]    kw_lim;
  logic [WIN_BITS-1:0]    kh_eff;
  logic [WIN_BITS-1:0]    kw_eff;

  // Position counters.
  logic [COL_BITS-1:0]  col;
  logic [ROW_BITS-1:0]  row;
  logic [LINE_BITS-1:0] cur_line;

  logic cfg_write;
  logic accept;
  logic row_end;
  logic frame_row_end;
  logic vert_ok;
  logic horiz_ok;

  // Stage 1: line store data arrives.
  logic                          s1_valid;
  logic [COL_BITS-1:0]           s1_col;
  logic [LINE_BITS-1:0]          s1_line;
  logic signed [SAMPLE_BITS-1:0] s1_px;
  logic                          s1_vert;
  logic                          s1_produce;
  logic                          s1_last;
  logic [WORD_BITS-1:0]          rd_word;
  logic [WORD_BITS-1:0]          wr_word;
  logic signed [SAMPLE_BITS-1:0] colmax;

  // Column maxima window and stage 2.
  logic signed [SAMPLE_BITS-1:0] colwin [MAX_WINDOW];
  logic                          s2_valid;
  logic                          s2_last;
  logic signed [SAMPLE_BITS-1:0] winmax;

  logic [CNT_BITS-1:0]    fifo_count;
  logic [SAMPLE_BITS:0]   fifo_out;

  // Register writes; pready is always high.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= IMAGE_WIDTH_RESET;
      image_height  <= IMAGE_HEIGHT_RESET;
      window_height <= WINDOW_HEIGHT_RESET;
      window_width  <= WINDOW_WIDTH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(paddr[3:2]))
        REG_IMAGE_WIDTH:   image_width   <= pwdata[CFG_DIM_BITS-1:0];
        REG_IMAGE_HEIGHT:  image_height  <= pwdata[CFG_DIM_BITS-1:0];
        REG_WINDOW_HEIGHT: window_height <= pwdata[CFG_WIN_BITS-1:0];
        REG_WINDOW_WIDTH:  window_width  <= pwdata[CFG_WIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (cfg_reg_t'(paddr[3:2]))
      REG_IMAGE_WIDTH:   prdata = DATA_BITS'(image_width);
      REG_IMAGE_HEIGHT:  prdata = DATA_BITS'(image_height);
      REG_WINDOW_HEIGHT: prdata = DATA_BITS'(window_height);
      REG_WINDOW_WIDTH:  prdata = DATA_BITS'(window_width);
      default:           prdata = '0;
    endcase
  end

  // Clamp the sizes: image to its limits, window to its limit and then to the image.
  always_comb begin
    if (image_width == '0) begin
      w_eff = WIDTH_BITS'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = WIDTH_BITS'(MAX_WIDTH);
    end else begin
      w_eff = WIDTH_BITS'(image_width);
    end

    if (image_height == '0) begin
      h_eff = HEIGHT_BITS'(1);
    end else if (32'(image_height) > 32'(HEIGHT_LIMIT)) begin
      h_eff = HEIGHT_BITS'(HEIGHT_LIMIT);
    end else begin
      h_eff = HEIGHT_BITS'(image_height);
    end

    if (window_height == '0) begin
      kh_lim = WIN_BITS'(1);
    end else if (32'(window_height) > 32'(MAX_WINDOW)) begin
      kh_lim = WIN_BITS'(MAX_WINDOW);
    end else begin
      kh_lim = WIN_BITS'(window_height);
    end

    if (window_width == '0) begin
      kw_lim = WIN_BITS'(1);
    end else if (32'(window_width) > 32'(MAX_WINDOW)) begin
      kw_lim = WIN_BITS'(MAX_WINDOW);
    end else begin
      kw_lim = WIN_BITS'(window_width);
    end

    kh_eff = (32'(kh_lim) > 32'(h_eff)) ? WIN_BITS'(h_eff) : kh_lim;
    kw_eff = (32'(kw_lim) > 32'(w_eff)) ? WIN_BITS'(w_eff) : kw_lim;
  end

  // Position decode for the incoming pixel.
  assign accept        = in_valid && !in_stall;
  assign row_end       = (32'(col) + 32'd1) == 32'(w_eff);
  assign frame_row_end = (32'(row) + 32'd1) == 32'(h_eff);
  assign vert_ok       = (32'(row) + 32'd1) >= 32'(kh_eff);
  assign horiz_ok      = (32'(col) + 32'd1) >= 32'(kw_eff);

  // Column, row and line counters; the line counter is the row modulo the line count.
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      col      <= '0;
      row      <= '0;
      cur_line <= '0;
    end else if (accept) begin
      if (row_end) begin
        col <= '0;
        if (frame_row_end) begin
          row      <= '0;
          cur_line <= '0;
        end else begin
          row      <= row + 1'b1;
          cur_line <= (cur_line == LINE_BITS'(LINES - 1)) ? '0 : cur_line + 1'b1;
        end
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // Stage 1 registers, loaded as the line store read is issued.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col     <= col;
      s1_line    <= cur_line;
      s1_px      <= pixel_value;
      s1_vert    <= vert_ok;
      s1_produce <= vert_ok && horiz_ok;
      s1_last    <= row_end && frame_row_end;
    end
  end

  swmp_line_store #(
    .DEPTH     (MAX_WIDTH),
    .WORD_BITS (WORD_BITS)
  ) u_line_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (rd_word),
    .wr_en   (s1_valid),
    .wr_addr (s1_col),
    .wr_data (wr_word)
  );

  // Column maximum over the lines that belong to the window, and the write-back word.
  // A lane's age is how many rows back it lies; the current lane holds the oldest row.
  always_comb begin
    int age;
    logic in_win;
    logic signed [SAMPLE_BITS-1:0] lane;
    colmax = s1_px;
    wr_word = rd_word;
    for (int j = 0; j < LINES; j++) begin
      if (j < int'(s1_line)) begin
        age = int'(s1_line) - j;
      end else begin
        age = int'(s1_line) + LINES - j;
      end
      in_win = s1_vert && (age < int'(kh_eff));
      lane = rd_word[j*SAMPLE_BITS +: SAMPLE_BITS];
      if (in_win && (lane > colmax)) begin
        colmax = lane;
      end
      if (j == int'(s1_line)) begin
        wr_word[j*SAMPLE_BITS +: SAMPLE_BITS] = s1_px;
      end
    end
  end

  // Column maxima shift window.
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      colwin[0] <= colmax;
      for (int t = 1; t < MAX_WINDOW; t++) begin
        colwin[t] <= colwin[t-1];
      end
    end
  end

  // Stage 2 registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1_produce;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_last <= s1_last;
    end
  end

  // Window maximum over the newest window-width column maxima.
  always_comb begin
    winmax = colwin[0];
    for (int t = 1; t < MAX_WINDOW; t++) begin
      if ((t < int'(kw_eff)) && (colwin[t] > winmax)) begin
        winmax = colwin[t];
      end
    end
  end

  swmp_out_fifo #(
    .DEPTH     (OUT_DEPTH),
    .DATA_BITS (SAMPLE_BITS + 1)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_valid),
    .push_data ({winmax, s2_last}),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (fifo_out),
    .count     (fifo_count)
  );

  assign pooled_value  = fifo_out[SAMPLE_BITS:1];
  assign last_of_frame = fifo_out[0];

  // Hold off input while the buffer could not absorb every word in flight.
  assign in_stall = (32'(fifo_count) + 32'(s1_valid) + 32'(s2_valid)) >= 32'(OUT_DEPTH);

endmodule

>>> rtl/swmp_checker.sv
// Port-level checks for the sliding window max pool block, bound to the top level.
// Uses swmp_pkg for the configuration port widths.
module swmp_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              pready,
  input logic [swmp_pkg::DATA_BITS-1:0]    prdata,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [SAMPLE_BITS-1:0]     pooled_value,
  input logic                              last_of_frame
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(pooled_value) && $stable(last_of_frame))
    else $error("result payload changed while stalled");

  // Reset empties the pipeline and opens the input.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

  // The configuration port never waits.
  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready && !$isunknown(prdata))
    else $error("configuration port not ready or read data unknown");

endmodule

bind sliding_window_max_pool_core swmp_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_swmp_checker (
  .clk           (clk),
  .rst           (rst),
  .pready        (pready),
  .prdata        (prdata),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .pooled_value  (pooled_value),
  .last_of_frame (last_of_frame)
);

>>> test/tb.sv
// Testbench for sliding_window_max_pool_core: streams pixel words over several frame
// sizes with random idling and checks every pooled word against a behavioral predictor.
// Depends on swmp_pkg and the RTL of sliding_window_max_pool_core.
`timescale 1ns / 100ps

module tb;
  import swmp_pkg::*;

  localparam int MAX_WIDTH     = 1024;
  localparam int MAX_WINDOW    = 8;
  localparam int SAMPLE_BITS   = 16;
  localparam int LINES         = MAX_WINDOW - 1;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MODE_ITEMS    = 140;
  localparam int TOTAL_ITEMS   = 420;

  // One full 5x5 frame for the reset geometry: extremes and all-negative windows.
  localparam logic signed [SAMPLE_BITS-1:0] FIRST_FRAME [25] = '{
    -32768, -32768, -32768,     -1, -32768,
    -32768,   -300, -32768, -32768, -32768,
     32767, -32768, -32768, -32768,      0,
         0,      1,     -1,    256,   -256,
     32767, -32768,  16384, -16385,    127
  };

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          last;
  } pooled_word_t;

  // Behavioral model of the pooling window plus the queue of pooled words it predicts.
  class max_pool_predictor;
    logic [CFG_DIM_BITS-1:0]       img_width;
    logic [CFG_DIM_BITS-1:0]       img_height;
    logic [CFG_WIN_BITS-1:0]       win_height;
    logic [CFG_WIN_BITS-1:0]       win_width;
    logic signed [SAMPLE_BITS-1:0] line_store [LINES*MAX_WIDTH];
    logic signed [SAMPLE_BITS-1:0] col_max [MAX_WINDOW];
    int unsigned                   col_idx;
    int unsigned                   row_idx;
    pooled_word_t                  pending_pooled [$];
    int                            mismatches;

    function new();
      img_width  = IMAGE_WIDTH_RESET;
      img_height = IMAGE_HEIGHT_RESET;
      win_height = WINDOW_HEIGHT_RESET;
      win_width  = WINDOW_WIDTH_RESET;
      col_idx    = 0;
      row_idx    = 0;
      mismatches = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // Any register write restarts the frame.
    function void set_reg(cfg_reg_t idx, logic [DATA_BITS-1:0] value);
      case (idx)
        REG_IMAGE_WIDTH:   img_width  = value[CFG_DIM_BITS-1:0];
        REG_IMAGE_HEIGHT:  img_height = value[CFG_DIM_BITS-1:0];
        REG_WINDOW_HEIGHT: win_height = value[CFG_WIN_BITS-1:0];
        REG_WINDOW_WIDTH:  win_width  = value[CFG_WIN_BITS-1:0];
        default: ;
      endcase
      col_idx = 0;
      row_idx = 0;
    endfunction

    function void take_pixel(logic signed [SAMPLE_BITS-1:0] px);
      int unsigned w, h, kh, kw, c, r, t;
      logic signed [SAMPLE_BITS-1:0] colmax, best;
      pooled_word_t word;
      w  = clamp(img_width, 1, MAX_WIDTH);
      h  = clamp(img_height, 1, HEIGHT_LIMIT);
      kh = clamp(clamp(win_height, 1, MAX_WINDOW), 1, h);
      kw = clamp(clamp(win_width, 1, MAX_WINDOW), 1, w);
      c  = (col_idx >= w) ? w - 1 : col_idx;
      r  = (row_idx >= h) ? h - 1 : row_idx;

      // Vertical maximum over the stored rows of this column.
      colmax = px;
      if (r + 1 >= kh) begin
        for (t = 1; t < kh; t++) begin
          if (line_store[((r - t) % LINES) * MAX_WIDTH + c] > colmax)
            colmax = line_store[((r - t) % LINES) * MAX_WIDTH + c];
        end
      end

      // Shift the column maxima and take the window maximum once the window is full.
      for (t = MAX_WINDOW - 1; t > 0; t--)
        col_max[t] = col_max[t-1];
      col_max[0] = colmax;
      if (r + 1 >= kh && c + 1 >= kw) begin
        best = col_max[0];
        for (t = 1; t < kw; t++) begin
          if (col_max[t] > best) best = col_max[t];
        end
        word.value = best;
        word.last  = (r == h - 1 && c == w - 1);
        pending_pooled = {pending_pooled, word};
      end

      line_store[(r % LINES) * MAX_WIDTH + c] = px;

      // Raster position of the next pixel; the frame wraps after its last sample.
      if (c + 1 >= w) begin
        col_idx = 0;
        row_idx = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_idx = c + 1;
        row_idx = r;
      end
    endfunction

    function void check_pooled(logic signed [SAMPLE_BITS-1:0] value, logic last);
      pooled_word_t want;
      if (pending_pooled.size() == 0) begin
        $error("pooled word with none expected: pooled_value %0d, last_of_frame %0b",
               value, last);
        mismatches++;
      end else begin
        want = pending_pooled.pop_front();
        if (value !== want.value) begin
          $error("pooled_value: expected %0d, got %0d", want.value, value);
          mismatches++;
        end
        if (last !== want.last) begin
          $error("last_of_frame: expected %0b, got %0b", want.last, last);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [ADDR_BITS-1:0]          paddr;
  logic [DATA_BITS-1:0]          pwdata;
  logic [DATA_BITS-1:0]          prdata;
  logic                          pready;
  logic                          in_valid;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] pixel_value;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [SAMPLE_BITS-1:0] pooled_value;
  logic                          last_of_frame;

  max_pool_predictor pool_model = new();
  int                pixels_sent = 0;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                hold_request = 0;

  sliding_window_max_pool_core #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .pixel_value   (pixel_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pooled_value  (pooled_value),
    .last_of_frame (last_of_frame)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Accepted words feed the predictor first, so a result at the same edge still lines up.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_stall === 1'b0) pool_model.take_pixel(pixel_value);
      if (out_valid === 1'b1 && !out_stall) pool_model.check_pooled(pooled_value, last_of_frame);
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: ends the run when no word moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  function automatic logic signed [SAMPLE_BITS-1:0] random_pixel();
    case ($urandom_range(7))
      0: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      1: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Offers one pixel word and holds it until accepted; the idling mode follows progress.
  task automatic send_pixel(input logic signed [SAMPLE_BITS-1:0] px);
    if (pixels_sent < MODE_ITEMS) begin
      send_idle_pct = 6;
      recv_idle_pct = 64;
    end else if (pixels_sent < 2 * MODE_ITEMS) begin
      send_idle_pct = 64;
      recv_idle_pct = 6;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    pixel_value <= px;
    do @(posedge clk); while (in_stall !== 1'b0);
    pixels_sent++;
  endtask

  // Setup and access cycle of one register write; the caller releases psel afterwards.
  task automatic reg_write(input cfg_reg_t idx, input logic [DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    pool_model.set_reg(idx, value);
  endtask

  // Waits until every predicted word has come out and the pipeline has emptied.
  task automatic wait_idle();
    @(posedge clk);
    while (pool_model.pending_pooled.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One geometry: program the registers while idle, then stream random pixel words.
  task automatic run_phase(input int unsigned width, input int unsigned height,
                           input int unsigned win_h, input int unsigned win_w,
                           input int items, input bit write_all, input int hold);
    int i;
    wait_idle();
    if (write_all || $urandom_range(1)) reg_write(REG_IMAGE_WIDTH, width);
    if (write_all || $urandom_range(1)) reg_write(REG_IMAGE_HEIGHT, height);
    if (write_all || $urandom_range(1)) reg_write(REG_WINDOW_HEIGHT, win_h);
    if (write_all || $urandom_range(1)) reg_write(REG_WINDOW_WIDTH, win_w);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    hold_request = hold;
    for (i = 0; i < items; i++) send_pixel(random_pixel());
    in_valid <= 1'b0;
  endtask

  initial begin
    int i;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    pixel_value <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // One whole frame at the reset geometry, ending on the frame wrap.
    for (i = 0; i < 25; i++) send_pixel(FIRST_FRAME[i]);
    in_valid <= 1'b0;

    // Fixed geometries: small frames, all-zero and oversized settings that clamp.
    run_phase(4, 3, 2, 2, 30, 1'b1, 0);
    run_phase(0, 0, 0, 0, 20, 1'b1, 0);
    run_phase(7, 6, 15, 15, 45, 1'b1, 0);
    run_phase(2047, 1, 1, 8, 40, 1'b1, 0);
    // Long receiver hold-off so the result buffer fills and the input stalls.
    run_phase(3, 2047, 1, 2, 30, 1'b1, 120);
    run_phase(9, 8, 8, 8, 75, 1'b1, 0);
    run_phase(1, 5, 2, 0, 15, 1'b1, 0);

    // Random small geometries; only some registers are rewritten each time.
    while (pixels_sent < TOTAL_ITEMS) begin
      run_phase($urandom_range(12), $urandom_range(10), $urandom_range(9),
                $urandom_range(9), $urandom_range(10, 60), 1'b0, 0);
    end

    wait_idle();
    if (pool_model.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/swmp_pkg.sv
rtl/swmp_line_store.sv
rtl/swmp_out_fifo.sv
rtl/sliding_window_max_pool_core.sv
rtl/swmp_checker.sv
test/tb.sv
